// ----- rtl/core/psm_pkg.sv -----
// ----------------------------------------------------------------------------
// Pointer shake magnifier package
// Shared payload types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package psm_pkg;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [31:0] stamp_ms;
  } psm_in_t;

  typedef struct packed {
    logic [11:0] scale_now;
    logic        magnified;
    logic [23:0] path_pixels;
    logic        shake_seen;
  } psm_out_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_SCALE  = 3'd0,
    REG_MIN_SCALE  = 3'd1,
    REG_RATE_UP    = 3'd2,
    REG_RATE_DOWN  = 3'd3,
    REG_THRESHOLD  = 3'd4,
    REG_WINDOW_MS  = 3'd5
  } psm_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREV_RD,
    ST_SEG_SQRT,
    ST_WRITE,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_FIRST_RD,
    ST_NET_SQRT,
    ST_DECIDE,
    ST_LERP,
    ST_OUT
  } psm_state_e;

  localparam logic [11:0] ScaleOne = 12'd256;
  localparam logic [11:0] MagLimit = 12'd261;
  localparam logic [31:0] RestLimit = 32'd1280;

endpackage
`default_nettype wire

// ----- rtl/core/pointer_shake_magnifier_top.sv -----
// ----------------------------------------------------------------------------
// Pointer shake magnifier
// Windowed pointer path measurement and smoothed magnification scale.
// ----------------------------------------------------------------------------
// One request is handled at a time. The walk over the sample ring (one RAM read
// per entry) and the bit-serial square root unit (run up to twice per request)
// set how long a request takes. A request that leaves fewer than two samples in
// the window skips the path sum and the net distance and finishes sooner.
// in_stall_o is high while a request is in work or its result waits.
`default_nettype none
module pointer_shake_magnifier_top #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [psm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [psm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire psm_pkg::psm_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output psm_pkg::psm_out_t                  out_data_o
);
  import psm_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(WINDOW_DEPTH);
  localparam logic [AW:0]   DepthW = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(WINDOW_DEPTH - 1);

  // Configuration registers.
  logic [11:0] max_scale_q, min_scale_q;
  logic [7:0]  rate_up_q, rate_down_q;
  logic [23:0] thresh_q;
  logic [15:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_scale_q <= 12'd1024;
      min_scale_q <= 12'd256;
      rate_up_q   <= 8'd77;
      rate_down_q <= 8'd38;
      thresh_q    <= 24'd4500;
      window_q    <= 16'd500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SCALE: max_scale_q <= cfg_data_i[11:0];
        REG_MIN_SCALE: min_scale_q <= cfg_data_i[11:0];
        REG_RATE_UP:   rate_up_q   <= cfg_data_i[7:0];
        REG_RATE_DOWN: rate_down_q <= cfg_data_i[7:0];
        REG_THRESHOLD: thresh_q    <= cfg_data_i;
        REG_WINDOW_MS: window_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Control state.
  psm_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] iter_q, iter_d;
  logic [31:0]   path_q, path_d;
  logic [11:0]   scale_q, scale_d, target_q, target_d;
  logic          shake_q, shake_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers.
  psm_in_t       smp_q;
  logic [33:0]   sum_q, sum_d;
  logic [24:0]   seg_q, seg_d;
  logic signed [15:0] fx_q, fx_d, fy_q, fy_d;

  // Ring memory: {x, y, time, seglen}.
  localparam int unsigned RW = 16 + 16 + 32 + 25;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic signed [15:0] rd_x, rd_y;
  logic [31:0]   rd_t;
  logic [24:0]   rd_seg;

  assign {rd_x, rd_y, rd_t, rd_seg} = ram_rdata;

  psm_ram #(.Width(RW), .Depth(WINDOW_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared square root unit.
  logic        sq_start, sq_done;
  logic [24:0] sq_root;
  logic signed [15:0] sq_ax, sq_ay;

  psm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .ax_i    (sq_ax),
    .ay_i    (sq_ay),
    .bx_i    (smp_q.pos_x),
    .by_i    (smp_q.pos_y),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Helpers.
  logic [AW-1:0] oldest, walk_addr;
  logic [31:0]   age;
  logic [35:0]   thr16;
  logic [35:0]   path10, net13;
  logic [11:0]   diff;
  logic [19:0]   lerp_p;
  logic [11:0]   lerp_step;
  logic [7:0]    rate;
  logic [AW:0]   wrap_sum, walk_sum;

  // Ring index arithmetic wraps by one compare and subtract.
  assign wrap_sum  = {1'b0, head_q} + DepthW - (AW+1)'(count_q);
  assign oldest    = (wrap_sum >= DepthW) ? AW'(wrap_sum - DepthW) : AW'(wrap_sum);
  assign walk_sum  = {1'b0, oldest} + (AW+1)'(iter_q);
  assign walk_addr = (walk_sum >= DepthW) ? AW'(walk_sum - DepthW) : AW'(walk_sum);
  assign age       = smp_q.stamp_ms - rd_t;
  assign thr16     = {8'd0, thresh_q, 4'd0};
  assign path10    = {4'd0, path_q} * 36'd10;
  assign net13     = ({11'd0, seg_q} + 36'd16) * 36'd13;
  assign rate      = (target_q > scale_q) ? rate_up_q : rate_down_q;
  assign diff      = (target_q >= scale_q) ? target_q - scale_q : scale_q - target_q;
  assign lerp_p    = diff * rate + 20'd128;
  assign lerp_step = lerp_p[19:8];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i && !in_stall_o) state_d = ST_PREV_RD;
      ST_PREV_RD:   state_d = (count_q != '0) ? ST_SEG_SQRT : ST_WRITE;
      ST_SEG_SQRT:  if (sq_done) state_d = ST_WRITE;
      ST_WRITE:     state_d = ST_EVICT_RD;
      ST_EVICT_RD:  state_d = ST_EVICT_CHK;
      ST_EVICT_CHK: begin
        if (age > {16'd0, window_q}) state_d = ST_EVICT_RD;
        else if (count_q >= CW'(2)) state_d = ST_SUM_RD;
        else state_d = ST_LERP;
      end
      ST_SUM_RD:    state_d = ST_SUM_ACC;
      ST_SUM_ACC:   state_d = (iter_q + CW'(1) >= count_q) ? ST_FIRST_RD : ST_SUM_RD;
      ST_FIRST_RD:  state_d = ST_NET_SQRT;
      ST_NET_SQRT:  if (sq_done) state_d = ST_DECIDE;
      ST_DECIDE:    state_d = ST_LERP;
      ST_LERP:      state_d = ST_OUT;
      ST_OUT:       if (!out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    iter_d      = iter_q;
    path_d      = path_q;
    scale_d     = scale_q;
    target_d    = target_q;
    shake_d     = shake_q;
    out_valid_d = out_valid_q;
    sum_d       = sum_q;
    seg_d       = seg_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = {smp_q.pos_x, smp_q.pos_y, smp_q.stamp_ms, seg_q};
    ram_raddr   = oldest;
    sq_start    = 1'b0;
    sq_ax       = rd_x;
    sq_ay       = rd_y;
    unique case (state_q)
      ST_IDLE: begin
        seg_d   = '0;
        shake_d = 1'b0;
        if (count_q >= DepthC) count_d = DepthC - CW'(1);
        ram_raddr = (head_q == '0) ? LastIdx : head_q - AW'(1);
      end
      ST_PREV_RD: begin
        if (count_q != '0) sq_start = 1'b1;
      end
      ST_SEG_SQRT: if (sq_done) seg_d = sq_root;
      ST_WRITE: begin
        ram_we  = 1'b1;
        head_d  = (head_q == LastIdx) ? '0 : head_q + AW'(1);
        count_d = count_q + CW'(1);
      end
      ST_EVICT_RD: ram_raddr = oldest;
      ST_EVICT_CHK: begin
        fx_d = rd_x;
        fy_d = rd_y;
        if (age > {16'd0, window_q}) begin
          count_d = count_q - CW'(1);
        end else if (count_q >= CW'(2)) begin
          iter_d = CW'(1);
          sum_d  = '0;
        end else begin
          path_d = '0;
        end
      end
      ST_SUM_RD: ram_raddr = walk_addr;
      ST_SUM_ACC: begin
        sum_d  = sum_q + 34'(rd_seg);
        iter_d = iter_q + CW'(1);
      end
      ST_FIRST_RD: begin
        path_d   = (sum_q > 34'hFFFFFFFF) ? 32'hFFFFFFFF : sum_q[31:0];
        sq_start = 1'b1;
        sq_ax    = fx_q;
        sq_ay    = fy_q;
      end
      ST_NET_SQRT: if (sq_done) seg_d = sq_root;
      ST_DECIDE: begin
        if ({4'd0, path_q} > thr16 && path10 > net13) begin
          target_d = max_scale_q;
          shake_d  = 1'b1;
        end else if (path_q < RestLimit) begin
          target_d = min_scale_q;
        end
      end
      ST_LERP: begin
        scale_d = (target_q >= scale_q) ? scale_q + lerp_step : scale_q - lerp_step;
        out_valid_d = 1'b1;
      end
      ST_OUT: if (!out_stall_i) out_valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      iter_q      <= '0;
      path_q      <= '0;
      scale_q     <= ScaleOne;
      target_q    <= ScaleOne;
      shake_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      iter_q      <= iter_d;
      path_q      <= path_d;
      scale_q     <= scale_d;
      target_q    <= target_d;
      shake_q     <= shake_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) smp_q <= in_data_i;
    sum_q <= sum_d;
    seg_q <= seg_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
  end

  // Ports.
  assign in_stall_o             = (state_q != ST_IDLE);
  assign out_valid_o            = out_valid_q;
  assign out_data_o.scale_now   = scale_q;
  assign out_data_o.magnified   = (scale_q > MagLimit);
  assign out_data_o.path_pixels = (path_q[31:28] != 4'd0) ? 24'hFFFFFF : path_q[27:4];
  assign out_data_o.shake_seen  = shake_q;

endmodule
`default_nettype wire

// ----- rtl/core/psm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module psm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/psm_sqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Computes floor(sqrt(256*(dx^2+dy^2))), one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psm_sqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] ax_i,
  input  wire logic signed [15:0] ay_i,
  input  wire logic signed [15:0] bx_i,
  input  wire logic signed [15:0] by_i,
  output logic                    done_o,
  output logic             [24:0] root_o
);

  // Radicand is below 2^42, so the root fits in 21 bits; 21 steps.
  logic        [4:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic        [1:0]  phase_q, phase_d;
  logic        [16:0] adx_q, ady_q;
  logic        [33:0] sq_q, sq_d;
  logic        [41:0] rem_q, rem_d;
  logic        [20:0] res_q, res_d;
  logic signed [16:0] dx_w, dy_w;
  logic        [16:0] mul_a;
  logic        [33:0] mul_p;
  logic        [41:0] trial;
  logic               fin_q;

  assign dx_w = 17'(bx_i) - 17'(ax_i);
  assign dy_w = 17'(by_i) - 17'(ay_i);
  assign mul_a = (phase_q == 2'd1) ? adx_q : ady_q;
  assign mul_p = mul_a * mul_a;
  // Trial subtrahend for the bit pair at position step.
  assign trial = {19'd0, res_q, 2'b01} << (2 * step_q);

  // One shared squarer, then one root bit per cycle (restoring form).
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    step_d  = step_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    res_d   = res_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 2'd1;
    end else if (busy_q) begin
      unique case (phase_q)
        2'd1: begin
          sq_d    = mul_p;
          phase_d = 2'd2;
        end
        2'd2: begin
          rem_d   = {sq_q + 34'(mul_p), 8'd0};
          res_d   = '0;
          step_d  = 5'd20;
          phase_d = 2'd3;
        end
        default: begin
          // res holds the upper root bits; test bit pair at position step.
          if (trial <= rem_q) begin
            rem_d = rem_q - trial;
            res_d = {res_q[19:0], 1'b1};
          end else begin
            res_d = {res_q[19:0], 1'b0};
          end
          if (step_q == 5'd0) begin
            busy_d  = 1'b0;
            phase_d = 2'd0;
          end else begin
            step_d = step_q - 5'd1;
          end
        end
      endcase
    end
  end

  // Done is flagged in the cycle after the last bit, when the root is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
      fin_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      fin_q   <= busy_q && phase_q == 2'd3 && step_q == 5'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      adx_q <= dx_w[16] ? 17'(-dx_w) : 17'(dx_w);
      ady_q <= dy_w[16] ? 17'(-dy_w) : 17'(dy_w);
    end
    step_q <= step_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign done_o = fin_q;
  assign root_o = {4'd0, res_q};

endmodule
`default_nettype wire
